// ===== src/linear_float_to_srgb8_pixel_assert.svh =====
// assertion macros for the linear float to srgb8 pixel block
`ifndef LINEAR_FLOAT_TO_SRGB8_PIXEL_ASSERT_SVH
`define LINEAR_FLOAT_TO_SRGB8_PIXEL_ASSERT_SVH
`ifndef SYNTHESIS
`define LFS_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lfs assertion failed");
`define LFS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lfs assertion failed");
`else
`define LFS_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define LFS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== src/lfs_pkg.sv =====
// shared types, constants and the srgb threshold table
`timescale 1ns / 1ps
`default_nettype none
package lfs_pkg;

    localparam int SRCH_STAGES = 8;
    localparam int KEY_W       = 27;
    localparam int ALPHA_WORK  = 4;
    localparam int PIPE_LAT    = SRCH_STAGES + 3;

    typedef enum logic {
        FMT_HALF   = 1'b0,
        FMT_SINGLE = 1'b1
    } t_fmt;

    typedef struct packed {
        logic              low;
        logic              inf;
        logic signed [8:0] exp;
        logic [23:0]       mant;
    } t_dec;

    typedef logic [255:0][KEY_W-1:0] t_thr_tab;

    // does the value with this key reach code k
    function automatic logic lfs_met(input logic [KEY_W-1:0] key, input int unsigned k);
        logic [383:0] lhs;
        logic [383:0] rhs;
        logic [383:0] b;
        logic [383:0] m;
        int unsigned  sh;
        int           i;
        if (key[26:23] > 4'd12) begin
            return 1'b1;
        end
        sh = 36 - int'(key[26:23]);
        m  = {360'd0, 1'b1, key[22:0]};
        if (k <= 10) begin
            lhs = m * 384'd32946;
            rhs = 384'((2 * k - 1) * 5) << sh;
            return lhs >= rhs;
        end
        lhs = m;
        for (i = 0; i < 4; i++) begin
            lhs = lhs * m;
        end
        for (i = 0; i < 12; i++) begin
            lhs = lhs * 384'd10761;
        end
        b   = 384'(40 * k + 541);
        rhs = b;
        for (i = 0; i < 11; i++) begin
            rhs = rhs * b;
        end
        rhs = rhs << (5 * sh);
        return lhs >= rhs;
    endfunction

    // smallest key that reaches code k
    function automatic logic [KEY_W-1:0] lfs_thr(input int unsigned k);
        logic [KEY_W-1:0] lo;
        logic [KEY_W-1:0] hi;
        logic [KEY_W:0]   sum;
        int               it;
        lo = '0;
        hi = KEY_W'(13) << 23;
        for (it = 0; it < KEY_W + 1; it++) begin
            if (lo < hi) begin
                sum = {1'b0, lo} + {1'b0, hi};
                if (lfs_met(sum[KEY_W:1], k)) begin
                    hi = sum[KEY_W:1];
                end else begin
                    lo = sum[KEY_W:1] + 1'b1;
                end
            end
        end
        return lo;
    endfunction

    function automatic t_thr_tab lfs_build_thr();
        t_thr_tab    tab;
        int unsigned k;
        tab[0] = '0;
        for (k = 1; k < 256; k++) begin
            tab[k] = lfs_thr(k);
        end
        return tab;
    endfunction

    localparam t_thr_tab COLOR_THR = lfs_build_thr();

endpackage
`default_nettype wire

// ===== src/lfs_decode.sv =====
// float bit pattern decode for half or single precision
`timescale 1ns / 1ps
`default_nettype none
module lfs_decode (
    input  wire logic [31:0]  i_bits,
    input  wire logic         i_fmt,
    output lfs_pkg::t_dec     o_dec
);
    import lfs_pkg::*;

    logic        sign;
    logic [7:0]  ex;
    logic [22:0] man;
    logic        top_ex;

    always_comb begin
        if (i_fmt == FMT_SINGLE) begin
            sign   = i_bits[31];
            ex     = i_bits[30:23];
            man    = i_bits[22:0];
            top_ex = (ex == 8'hFF);
            o_dec.exp  = $signed({1'b0, ex}) - 9'sd127;
        end else begin
            sign   = i_bits[15];
            ex     = {3'd0, i_bits[14:10]};
            man    = {i_bits[9:0], 13'd0};
            top_ex = (ex == 8'h1F);
            o_dec.exp  = $signed({1'b0, ex}) - 9'sd15;
        end
        o_dec.mant = {1'b1, man};
        if (top_ex) begin
            o_dec.low = (man != '0) | sign;
            o_dec.inf = (man == '0) & ~sign;
        end else begin
            o_dec.low = sign | (ex == '0);
            o_dec.inf = 1'b0;
        end
    end
endmodule
`default_nettype wire

// ===== src/lfs_srgb_search.sv =====
// pipelined binary search of the srgb threshold table, one code bit per stage
`timescale 1ns / 1ps
`default_nettype none
module lfs_srgb_search (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    input  wire lfs_pkg::t_dec i_dec,
    output logic               o_valid,
    output logic [7:0]         o_code
);
    import lfs_pkg::*;

    logic                    r_v    [0:SRCH_STAGES];
    logic                    r_zero [0:SRCH_STAGES];
    logic                    r_sat  [0:SRCH_STAGES];
    logic [KEY_W-1:0]        r_key  [0:SRCH_STAGES];
    logic [7:0]              r_c    [0:SRCH_STAGES];
    logic signed [8:0]       n_ei;

    assign n_ei = i_dec.exp + 9'sd13;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else begin
            r_v[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_zero[0] <= i_dec.low | (~i_dec.inf & (i_dec.exp < -9'sd13));
        r_sat[0]  <= i_dec.inf | (i_dec.exp >= 9'sd0);
        r_key[0]  <= {n_ei[3:0], i_dec.mant[22:0]};
        r_c[0]    <= '0;
    end

    for (genvar s = 1; s <= SRCH_STAGES; s++) begin : g_stage
        logic [7:0] n_try;
        assign n_try = r_c[s-1] | (8'd1 << (SRCH_STAGES - s));

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[s] <= 1'b0;
            end else begin
                r_v[s] <= r_v[s-1];
            end
        end

        always_ff @(posedge i_clk) begin
            r_zero[s] <= r_zero[s-1];
            r_sat[s]  <= r_sat[s-1];
            r_key[s]  <= r_key[s-1];
            r_c[s]    <= (r_key[s-1] >= COLOR_THR[n_try]) ? n_try : r_c[s-1];
        end
    end

    assign o_valid = r_v[SRCH_STAGES];
    assign o_code  = r_zero[SRCH_STAGES] ? 8'd0 :
                     r_sat[SRCH_STAGES]  ? 8'd255 : r_c[SRCH_STAGES];
endmodule
`default_nettype wire

// ===== src/lfs_alpha.sv =====
// alpha scale by 255, single precision rounding, truncation and saturation
`timescale 1ns / 1ps
`default_nettype none
module lfs_alpha (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    input  wire lfs_pkg::t_dec i_dec,
    output logic               o_valid,
    output logic [7:0]         o_code
);
    import lfs_pkg::*;

    localparam int DLY = SRCH_STAGES + 1 - ALPHA_WORK;

    logic        r_v [0:ALPHA_WORK + DLY - 1];
    logic [7:0]  r_code [ALPHA_WORK - 1:ALPHA_WORK + DLY - 1];

    logic        r0_zero, r0_sat;
    logic [3:0]  r0_ne;
    logic [23:0] r0_m;
    logic        r1_zero, r1_sat;
    logic [3:0]  r1_ne;
    logic [31:0] r1_p;
    logic        r2_zero, r2_sat;
    logic [25:0] r2_q;
    logic [4:0]  r2_sh;

    logic        n_s8;
    logic [24:0] n_q;
    logic        n_up;
    logic [8:0]  n_ne;
    logic [25:0] n_r;

    assign n_ne = 9'sd0 - i_dec.exp;
    assign n_s8 = r1_p[31];
    assign n_q  = n_s8 ? {1'b0, r1_p[31:8]} : r1_p[31:7];
    assign n_up = n_s8 ? (r1_p[7] & ((r1_p[6:0] != '0) | r1_p[8]))
                       : (r1_p[6] & ((r1_p[5:0] != '0) | r1_p[7]));
    assign n_r  = r2_q >> r2_sh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < ALPHA_WORK + DLY; i++) begin
                r_v[i] <= 1'b0;
            end
        end else begin
            r_v[0] <= i_valid;
            for (int i = 1; i < ALPHA_WORK + DLY; i++) begin
                r_v[i] <= r_v[i-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r0_zero <= i_dec.low | (~i_dec.inf & (i_dec.exp < -9'sd8));
        r0_sat  <= i_dec.inf | (i_dec.exp >= 9'sd1);
        r0_ne   <= n_ne[3:0];
        r0_m    <= i_dec.mant;

        r1_zero <= r0_zero;
        r1_sat  <= r0_sat;
        r1_ne   <= r0_ne;
        r1_p    <= {8'd0, r0_m} * 32'd255;

        r2_zero <= r1_zero;
        r2_sat  <= r1_sat;
        r2_q    <= {1'b0, n_q} + {25'd0, n_up};
        r2_sh   <= 5'd23 + {1'b0, r1_ne} - (n_s8 ? 5'd8 : 5'd7);

        r_code[ALPHA_WORK-1] <= r2_zero ? 8'd0 :
                                (r2_sat | (n_r > 26'd255)) ? 8'd255 : n_r[7:0];
        for (int i = ALPHA_WORK; i < ALPHA_WORK + DLY; i++) begin
            r_code[i] <= r_code[i-1];
        end
    end

    assign o_valid = r_v[ALPHA_WORK + DLY - 1];
    assign o_code  = r_code[ALPHA_WORK + DLY - 1];
endmodule
`default_nettype wire

// ===== src/linear_float_to_srgb8_pixel.sv =====
// top level: linear float pixel to 8-bit srgb pixel, fully pipelined
//
//   channel   signals                                    dir
//   request   start, busy, i_red/green/blue/alpha_bits  in
//   result    o_result_valid, o_red/green/blue/alpha_code out
//   config    i_cfg_valid, o_cfg_ready, i_cfg_data       in
//
// one pixel accepted every cycle, busy stays low
// result strobe follows the accepting edge through the input register,
// the registered search of the threshold table and the output register
// synchronous active-low reset clears valid bits and the format register
// nothing stalls: results are taken the cycle they appear
`timescale 1ns / 1ps
`default_nettype none
`include "linear_float_to_srgb8_pixel_assert.svh"
module linear_float_to_srgb8_pixel (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [31:0] i_red_bits,
    input  wire logic [31:0] i_green_bits,
    input  wire logic [31:0] i_blue_bits,
    input  wire logic [31:0] i_alpha_bits,
    output logic             o_result_valid,
    output logic [7:0]       o_red_code,
    output logic [7:0]       o_green_code,
    output logic [7:0]       o_blue_code,
    output logic [7:0]       o_alpha_code,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic        i_cfg_data
);
    import lfs_pkg::*;

    logic        r_fmt;
    logic        r_in_v;
    logic [31:0] r_bits [0:3];
    t_dec        dec    [0:3];
    logic        col_v  [0:2];
    logic [7:0]  col_c  [0:2];
    logic        a_v;
    logic [7:0]  a_c;
    logic        r_out_v;
    logic [7:0]  r_code [0:3];

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fmt   <= FMT_HALF;
            r_in_v  <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_fmt <= i_cfg_data;
            end
            r_in_v  <= start && !busy;
            r_out_v <= col_v[0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_bits[0] <= i_red_bits;
        r_bits[1] <= i_green_bits;
        r_bits[2] <= i_blue_bits;
        r_bits[3] <= i_alpha_bits;
        r_code[0] <= col_c[0];
        r_code[1] <= col_c[1];
        r_code[2] <= col_c[2];
        r_code[3] <= a_c;
    end

    for (genvar c = 0; c < 4; c++) begin : g_dec
        lfs_decode u_dec (
            .i_bits (r_bits[c]),
            .i_fmt  (r_fmt),
            .o_dec  (dec[c])
        );
    end

    for (genvar c = 0; c < 3; c++) begin : g_col
        lfs_srgb_search u_srch (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (r_in_v),
            .i_dec   (dec[c]),
            .o_valid (col_v[c]),
            .o_code  (col_c[c])
        );
    end

    lfs_alpha u_alpha (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_in_v),
        .i_dec   (dec[3]),
        .o_valid (a_v),
        .o_code  (a_c)
    );

    assign o_result_valid = r_out_v;
    assign o_red_code     = r_code[0];
    assign o_green_code   = r_code[1];
    assign o_blue_code    = r_code[2];
    assign o_alpha_code   = r_code[3];

    `LFS_ASSERT_IMPLY(a_lane_align, i_clk, i_rst_n, col_v[0] || a_v, col_v[0] && col_v[1] && col_v[2] && a_v)
    `LFS_ASSERT_IMPLY(a_latency, i_clk, i_rst_n, o_result_valid, $past(start, PIPE_LAT))
    `LFS_ASSERT_NEXT(a_no_drop, i_clk, i_rst_n, col_v[0], o_result_valid)

endmodule
`default_nettype wire

// ===== dv/tb_top.sv =====
// testbench for linear_float_to_srgb8_pixel: random and directed pixels, checked against a predictor
`timescale 1ns / 1ps
module tb_top;
    import lfs_pkg::*;

    typedef enum logic [1:0] {
        REQ_PIXEL,
        REQ_FORMAT,
        REQ_DRAIN
    } t_req_kind;

    typedef struct {
        t_req_kind   kind;
        logic        fmt;
        logic [31:0] ch[4];
    } t_request;

    typedef struct {
        logic [7:0] code[4];
    } t_codes;

    localparam int SETTLE = PIPE_LAT + 6;
    localparam int LIMIT  = 200000;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [31:0] i_red_bits, i_green_bits, i_blue_bits, i_alpha_bits;
    logic        o_result_valid;
    logic [7:0]  o_red_code, o_green_code, o_blue_code, o_alpha_code;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic        i_cfg_data;

    t_request pending[$];
    t_codes   expected_codes[$];
    logic     fmt_now;
    int       gap_left;
    int       quiet;
    int       mismatches;
    int       cycles;
    bit       fill_done;
    bit       drive_done;

    linear_float_to_srgb8_pixel dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_red_bits(i_red_bits), .i_green_bits(i_green_bits),
        .i_blue_bits(i_blue_bits), .i_alpha_bits(i_alpha_bits),
        .o_result_valid(o_result_valid), .o_red_code(o_red_code),
        .o_green_code(o_green_code), .o_blue_code(o_blue_code),
        .o_alpha_code(o_alpha_code), .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // 0 normal, 1 low or nan, 2 positive infinity
    function automatic int classify(input logic [31:0] b, input logic fmt,
                                    output logic [23:0] m, output int e);
        m = '0;
        e = 0;
        if (fmt == FMT_SINGLE) begin
            if (b[30:23] == 8'hff) return (b[22:0] != 0 || b[31]) ? 1 : 2;
            if (b[31] || b[30:23] == 0) return 1;
            e = int'(b[30:23]) - 127;
            m = {1'b1, b[22:0]};
        end else begin
            if (b[14:10] == 5'h1f) return (b[9:0] != 0 || b[15]) ? 1 : 2;
            if (b[15] || b[14:10] == 0) return 1;
            e = int'(b[14:10]) - 15;
            m = {1'b1, b[9:0], 13'd0};
        end
        return 0;
    endfunction

    function automatic logic [7:0] gamma_code(input logic [31:0] b, input logic fmt);
        logic [23:0]  m;
        int           e;
        int           cls;
        int           sh;
        int           lo;
        int           hi;
        int           mid;
        logic [63:0]  lin;
        logic [383:0] lhs;
        logic [383:0] rhs;
        logic [383:0] base;
        cls = classify(b, fmt, m, e);
        if (cls == 1) return 8'd0;
        if (cls == 2 || e >= 0) return 8'd255;
        if (e < -13) return 8'd0;
        sh = 23 - e;
        lin = 64'(m) * 64'd32946;
        for (int k = 1; k <= 10; k++) begin
            if (lin < (64'((2 * k - 1) * 5) << sh)) return 8'(k - 1);
        end
        lhs = 384'(m);
        for (int i = 0; i < 4; i++) lhs = lhs * 384'(m);
        for (int i = 0; i < 12; i++) lhs = lhs * 384'd10761;
        lo = 10;
        hi = 255;
        while (lo < hi) begin
            mid = (lo + hi + 1) / 2;
            base = 384'(40 * mid + 541);
            rhs = base;
            for (int i = 0; i < 11; i++) rhs = rhs * base;
            rhs = rhs << (5 * sh);
            if (lhs >= rhs) lo = mid;
            else hi = mid - 1;
        end
        return 8'(lo);
    endfunction

    function automatic logic [7:0] alpha_code(input logic [31:0] b, input logic fmt);
        logic [23:0] m;
        int          e;
        int          cls;
        int          s;
        int          down;
        logic [31:0] p;
        logic [31:0] q;
        logic [31:0] rem;
        logic [31:0] half;
        logic [31:0] r;
        cls = classify(b, fmt, m, e);
        if (cls == 1) return 8'd0;
        if (cls == 2 || e >= 1) return 8'd255;
        if (e < -8) return 8'd0;
        p = 32'(m) * 32'd255;
        s = p[31] ? 8 : 7;
        q = p >> s;
        rem = p & ((32'd1 << s) - 1);
        half = 32'd1 << (s - 1);
        if (rem > half || (rem == half && q[0])) q = q + 1;
        down = 23 - e - s;
        r = q >> down;
        return (r > 255) ? 8'd255 : r[7:0];
    endfunction

    // mostly in-range values for the chosen format, sometimes raw bits
    function automatic logic [31:0] pick_channel(input logic fmt, input bit is_alpha);
        logic [31:0] b;
        b = $urandom;
        if ($urandom_range(0, 9) < 2) return b;
        if (fmt == FMT_SINGLE) begin
            b[31] = ($urandom_range(0, 15) == 0);
            b[30:23] = is_alpha ? 8'($urandom_range(116, 128)) : 8'($urandom_range(112, 127));
            if ($urandom_range(0, 19) == 0) b[30:23] = $urandom_range(0, 1) ? 8'hff : 8'h00;
        end else begin
            b[15] = ($urandom_range(0, 15) == 0);
            b[14:10] = is_alpha ? 5'($urandom_range(7, 16)) : 5'($urandom_range(1, 15));
            if ($urandom_range(0, 19) == 0) b[14:10] = $urandom_range(0, 1) ? 5'h1f : 5'h00;
        end
        return b;
    endfunction

    task automatic add_pixel(input logic [31:0] r, input logic [31:0] g,
                             input logic [31:0] bl, input logic [31:0] a);
        t_request q;
        q.kind = REQ_PIXEL;
        q.fmt = 1'b0;
        q.ch[0] = r;
        q.ch[1] = g;
        q.ch[2] = bl;
        q.ch[3] = a;
        pending.push_back(q);
    endtask

    task automatic add_marker(input t_req_kind kind, input logic fmt);
        t_request q;
        q.kind = kind;
        q.fmt = fmt;
        for (int i = 0; i < 4; i++) q.ch[i] = '0;
        pending.push_back(q);
    endtask

    initial begin
        logic fmt;
        // half format (reset value), extremes and special values
        add_pixel(32'h0000_0000, 32'h0000_8000, 32'h0000_7c00, 32'h0000_3c00);
        add_pixel(32'h0000_fc00, 32'h0000_7e00, 32'h0000_0001, 32'h0000_4000);
        add_pixel(32'h0000_3c00, 32'h0000_3bff, 32'h0000_1a69, 32'h0000_3800);
        add_pixel(32'h0000_1a6a, 32'h0000_0400, 32'h0000_7bff, 32'h0000_7bff);
        add_pixel(32'hffff_2000, 32'h1234_0fff, 32'h0000_03ff, 32'h0000_1c00);
        add_pixel(32'hffff_ffff, 32'h0000_7fff, 32'h0000_3555, 32'h0000_fc00);
        add_marker(REQ_FORMAT, FMT_SINGLE);
        add_pixel(32'h0000_0000, 32'h8000_0000, 32'h7f80_0000, 32'h3f80_0000);
        add_pixel(32'hff80_0000, 32'h7fc0_0000, 32'h0000_0001, 32'h4000_0000);
        add_pixel(32'h3f80_0000, 32'h3f7f_ffff, 32'h3b4d_2e1c, 32'h3f7f_ffff);
        add_pixel(32'h3b4d_2e1b, 32'h3b4d_2e1d, 32'h3900_0000, 32'h3b80_0000);
        add_pixel(32'h0080_0000, 32'h7f7f_ffff, 32'h3800_0000, 32'h7f7f_ffff);
        add_pixel(32'hffff_ffff, 32'h7f80_0001, 32'h3f00_0000, 32'h3bff_ffff);
        add_pixel(32'h3e80_0000, 32'h3d00_0000, 32'h3c00_0000, 32'hbf80_0000);
        add_marker(REQ_DRAIN, 1'b0);
        fmt = FMT_SINGLE;
        for (int n = 0; n < 450; n++) begin
            if (n % 75 == 0) begin
                fmt = (n == 0) ? FMT_HALF : logic'($urandom_range(0, 1));
                add_marker(REQ_FORMAT, fmt);
            end
            add_pixel(pick_channel(fmt, 0), pick_channel(fmt, 0),
                      pick_channel(fmt, 0), pick_channel(fmt, 1));
        end
        fill_done = 1'b1;
        wait (drive_done && expected_codes.size() == 0);
        repeat (SETTLE) @(posedge i_clk);
        if (mismatches == 0 && expected_codes.size() == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("tb_top failed");
            $finish;
        end
    end

    initial begin
        i_rst_n = 1'b0;
        start = 1'b0;
        i_red_bits = '0;
        i_green_bits = '0;
        i_blue_bits = '0;
        i_alpha_bits = '0;
        i_cfg_valid = 1'b0;
        i_cfg_data = 1'b0;
        fmt_now = FMT_HALF;
        gap_left = 0;
        quiet = 0;
        mismatches = 0;
        cycles = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // driver
    always @(posedge i_clk) begin
        t_codes   c;
        t_request head;
        logic     nxt_start;
        logic     nxt_cfg;
        logic     present;
        if (i_rst_n) begin
            nxt_start = start;
            nxt_cfg = i_cfg_valid;
            present = 1'b0;
            quiet = (expected_codes.size() == 0) ? quiet + 1 : 0;
            if (i_cfg_valid && o_cfg_ready) begin
                fmt_now = i_cfg_data;
                nxt_cfg = 1'b0;
                void'(pending.pop_front());
            end
            if (start && !busy) begin
                head = pending.pop_front();
                c.code[0] = gamma_code(head.ch[0], fmt_now);
                c.code[1] = gamma_code(head.ch[1], fmt_now);
                c.code[2] = gamma_code(head.ch[2], fmt_now);
                c.code[3] = alpha_code(head.ch[3], fmt_now);
                expected_codes.push_back(c);
                nxt_start = 1'b0;
                quiet = 0;
            end
            if (!nxt_start && !nxt_cfg) begin
                if (gap_left > 0) begin
                    gap_left = gap_left - 1;
                end else if (pending.size() == 0) begin
                    if (fill_done) drive_done = 1'b1;
                end else begin
                    head = pending[0];
                    if (head.kind == REQ_DRAIN) begin
                        if (quiet >= SETTLE) void'(pending.pop_front());
                    end else if (head.kind == REQ_FORMAT) begin
                        if (quiet >= SETTLE) begin
                            nxt_cfg = 1'b1;
                            i_cfg_data <= head.fmt;
                        end
                    end else if (pending.size() > 60 && $urandom_range(0, 7) == 0) begin
                        gap_left = $urandom_range(1, 7) - 1;
                    end else begin
                        present = 1'b1;
                        nxt_start = 1'b1;
                    end
                end
            end
            if (present) begin
                i_red_bits <= head.ch[0];
                i_green_bits <= head.ch[1];
                i_blue_bits <= head.ch[2];
                i_alpha_bits <= head.ch[3];
            end
            start <= nxt_start;
            i_cfg_valid <= nxt_cfg;
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_codes want;
        logic [7:0] got[4];
        if (i_rst_n && o_result_valid) begin
            got[0] = o_red_code;
            got[1] = o_green_code;
            got[2] = o_blue_code;
            got[3] = o_alpha_code;
            if (expected_codes.size() == 0) begin
                mismatches = mismatches + 1;
                if (mismatches <= 10) $display("unexpected result %p", got);
            end else begin
                want = expected_codes.pop_front();
                for (int i = 0; i < 4; i++) begin
                    if (got[i] !== want.code[i]) begin
                        mismatches = mismatches + 1;
                        if (mismatches <= 10) begin
                            $display("channel %0d mismatch: expected %0d got %0d",
                                     i, want.code[i], got[i]);
                        end
                    end
                end
            end
        end
    end

endmodule
